// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the tilt filter rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ICTF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// next-cycle implication
`define ICTF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

// ===== rtl/core/ictf_pkg.sv =====
// ----------------------------------------------------------------------------
// ictf_pkg
// types, constants and helpers of the imu tilt complementary filter
// ----------------------------------------------------------------------------
package ictf_pkg;

	// divider: numerator width, divisor width, quotient bits per cycle
	localparam int DIV_NW   = 52;
	localparam int DIV_DW   = 11;
	localparam int DIV_STEP = 4;
	localparam int DIV_ITER = DIV_NW / DIV_STEP;
	localparam int DIV_CW   = $clog2(DIV_ITER);

	// shared multiplier operand and product widths
	localparam int MUL_AW = 33;
	localparam int MUL_BW = 18;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	// cordic working widths
	localparam int CRD_W    = 36;
	localparam int ATAN_LEN = 24;
	localparam int ATAN_IW  = $clog2(ATAN_LEN);

	// width of intermediate values that are saturated to q16.16
	localparam int SAT_W = 54;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_RANGE_SEL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RANGE_SEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET_Z   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_WEIGHT    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_WEIGHT     = 3'd6;

	localparam logic [1:0]  GYRO_RANGE_RST   = 2'd1;
	localparam logic [1:0]  ACCEL_RANGE_RST  = 2'd0;
	localparam logic [16:0] ACCEL_WEIGHT_RST = 17'd1311;
	localparam logic [16:0] GYRO_WEIGHT_RST  = 17'd64225;

	localparam logic signed [16:0] TEMP_OFS = 17'sd12412;
	localparam logic [DIV_DW-1:0]  TEMP_DIV = 11'd340;
	localparam logic [DIV_DW-1:0]  INT_DIV  = 11'd1000;
	localparam logic [DIV_DW-1:0]  RATE_DIV [0:3] = '{11'd1310, 11'd655, 11'd328, 11'd164};

	localparam logic signed [31:0] HALF_TURN_Q16 = 32'sd11796480;

	localparam logic [21:0] ATAN_DEG_Q16 [0:ATAN_LEN-1] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
		22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
		22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
		22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
	};

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV_LOAD,
		S_DIV_RUN,
		S_DIV_DONE,
		S_MUL,
		S_CORDIC_LOAD,
		S_CORDIC_RUN,
		S_MIX_A,
		S_MIX_B,
		S_MIX_C,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		JOB_TEMP,
		JOB_RATE_X,
		JOB_RATE_Y,
		JOB_RATE_Z,
		JOB_INT_X,
		JOB_INT_Y,
		JOB_INT_Z
	} job_t;

	typedef struct packed {
		logic signed [15:0] accel_raw_x;
		logic signed [15:0] accel_raw_y;
		logic signed [15:0] accel_raw_z;
		logic signed [15:0] temp_raw;
		logic signed [15:0] gyro_raw_x;
		logic signed [15:0] gyro_raw_y;
		logic signed [15:0] gyro_raw_z;
		logic        [15:0] elapsed_ms;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] angle_x;
		logic signed [31:0] angle_y;
		logic signed [31:0] angle_z;
		logic signed [31:0] tilt_acc_x;
		logic signed [31:0] tilt_acc_y;
		logic signed [31:0] rate_x;
		logic signed [31:0] rate_y;
		logic signed [31:0] rate_z;
		logic signed [31:0] accel_g_x;
		logic signed [31:0] accel_g_y;
		logic signed [31:0] accel_g_z;
		logic signed [31:0] temperature;
	} out_item_t;

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat_q16(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = SAT_W'(32'sh7fffffff);
		lo = SAT_W'(-33'sh080000000);
		if (v > hi) begin
			return 32'sh7fffffff;
		end else if (v < lo) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

// ===== rtl/core/ictf_stream_if.sv =====
// ----------------------------------------------------------------------------
// ictf_stream_if
// valid/ready stream channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface ictf_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/core/imu_tilt_complementary_filter_unit.sv =====
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter_unit
// six-axis tilt estimator: scaling, gyro integration, cordic tilt and mixing
// ----------------------------------------------------------------------------
// usage:
//  samples carries one raw sample set (accel, temperature, gyro, elapsed ms)
//  per transfer; results carries one set of q16.16 outputs per sample set
//  registers are written through cfg_we / cfg_index / cfg_wdata; the user
//  must do so only while idle, the block itself does not enforce this
// sequencing:
//  one sample set at a time; samples.ready is high only while idle
//  each set passes the shared radix-16 divider (7 divisions), the shared
//  multiplier and the cordic iterations, which stop early when a
//  rotation hits zero
// reset:
//  arst_n clears the sequencer, the gyro integrals, the seed flag and loads
//  the register defaults; the first sample set after reset seeds x and y
// stall:
//  a finished result sits in the output register; the block takes the next
//  sample set meanwhile and only waits at its end until that result is taken
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imu_tilt_complementary_filter_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	ictf_stream_if.sink                          samples,
	ictf_stream_if.source                        results,
	input  logic                                 cfg_we,
	input  logic [ictf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                          cfg_wdata
);

	localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
	localparam int DNW = ictf_pkg::DIV_NW;
	localparam int DDW = ictf_pkg::DIV_DW;
	localparam int CW  = ictf_pkg::CRD_W;
	localparam int PW  = ictf_pkg::MUL_PW;
	localparam int SW  = ictf_pkg::SAT_W;

	// ------------------------------------------------------------------
	// registers
	// ------------------------------------------------------------------
	ictf_pkg::state_t state_q, state_d;
	ictf_pkg::job_t   job_q, job_d;

	logic [1:0]               gyro_range_q;
	logic [1:0]               accel_range_q;
	logic signed [31:0]       gyro_offset_q [3];
	logic [16:0]              accel_weight_q;
	logic [16:0]              gyro_weight_q;

	logic signed [31:0]       integ_q [3];
	logic                     seeded_q;
	logic                     out_valid_q;
	logic [ictf_pkg::DIV_CW-1:0] cnt_q;
	logic [STEP_W-1:0]        step_q;
	logic                     axis_q;

	ictf_pkg::in_item_t       in_q;
	ictf_pkg::out_item_t      out_q;
	logic [DNW-1:0]           dq_q;
	logic [DDW-1:0]           rem_q;
	logic [DDW-1:0]           div_d_q;
	logic                     neg_q;
	logic signed [PW-1:0]     prod_q;
	logic signed [PW-1:0]     acc_q;
	logic signed [CW-1:0]     cx_q, cy_q;
	logic signed [31:0]       cz_q;
	logic signed [31:0]       temp_q;
	logic signed [31:0]       rate_q [3];
	logic signed [31:0]       tilt_q [2];
	logic signed [31:0]       angle_q [2];

	// ------------------------------------------------------------------
	// combinational datapath
	// ------------------------------------------------------------------
	logic [1:0]               ax_idx;
	logic signed [15:0]       raw_sel;
	logic signed [16:0]       tv;
	logic [16:0]              tmag;
	logic [16:0]              rmag;
	logic [DDW-1:0]           div_d;
	logic                     num_neg;
	logic [DNW-1:0]           num_mag;
	logic [DNW-1:0]           dq_next;
	logic [DDW-1:0]           rem_next;
	logic [DDW:0]             rtmp;
	logic signed [DNW:0]      qsig;
	logic signed [31:0]       rate_new;
	logic signed [31:0]       integ_new;
	logic signed [ictf_pkg::MUL_AW-1:0] mul_a;
	logic signed [ictf_pkg::MUL_BW-1:0] mul_b;
	logic signed [PW-1:0]     mul_p;
	logic signed [15:0]       cl_y;
	logic signed [15:0]       cl_o;
	logic [16:0]              cl_omag;
	logic signed [17:0]       cl_x;
	logic signed [CW-1:0]     cl_xs, cl_ys;
	logic [ictf_pkg::ATAN_IW-1:0] atan_idx;
	logic signed [CW-1:0]     xsh, ysh;
	logic signed [31:0]       atan_v;
	logic                     cordic_end;
	logic signed [31:0]       zs;
	logic signed [31:0]       tilt_new;
	logic signed [PW:0]       msum;
	logic [PW:0]              mmag;
	logic [PW:0]              mr;
	logic signed [PW:0]       mval;
	logic signed [31:0]       angle_new;
	logic                     out_load;
	logic [2:0]               g_shift;

	// axis served by the current job
	always_comb begin
		case (job_q)
			ictf_pkg::JOB_RATE_Y, ictf_pkg::JOB_INT_Y: ax_idx = 2'd1;
			ictf_pkg::JOB_RATE_Z, ictf_pkg::JOB_INT_Z: ax_idx = 2'd2;
			default: ax_idx = 2'd0;
		endcase
	end

	always_comb begin
		case (ax_idx)
			2'd1: raw_sel = in_q.gyro_raw_y;
			2'd2: raw_sel = in_q.gyro_raw_z;
			default: raw_sel = in_q.gyro_raw_x;
		endcase
	end

	// divider operand: |numerator| + divisor/2, sign kept apart (round half away)
	always_comb begin
		tv   = 17'(in_q.temp_raw) + ictf_pkg::TEMP_OFS;
		tmag = tv[16] ? 17'(-tv) : 17'(tv);
		rmag = raw_sel[15] ? 17'(-17'(raw_sel)) : 17'(raw_sel);
		case (job_q)
			ictf_pkg::JOB_TEMP: begin
				div_d   = ictf_pkg::TEMP_DIV;
				num_neg = tv[16];
				num_mag = DNW'(tmag) << 16;
			end
			ictf_pkg::JOB_RATE_X, ictf_pkg::JOB_RATE_Y, ictf_pkg::JOB_RATE_Z: begin
				div_d   = ictf_pkg::RATE_DIV[gyro_range_q];
				num_neg = raw_sel[15];
				// raw * 655360 = raw * 10 * 65536
				num_mag = ((DNW'(rmag) << 3) + (DNW'(rmag) << 1)) << 16;
			end
			default: begin
				div_d   = ictf_pkg::INT_DIV;
				num_neg = prod_q[PW-1];
				num_mag = DNW'(prod_q[PW-1] ? -prod_q : prod_q);
			end
		endcase
		num_mag = num_mag + DNW'(div_d >> 1);
	end

	// radix-16 restoring division step
	always_comb begin
		dq_next  = dq_q;
		rem_next = rem_q;
		rtmp     = '0;
		for (int k = 0; k < ictf_pkg::DIV_STEP; k++) begin
			rtmp    = {rem_next, dq_next[DNW-1]};
			dq_next = dq_next << 1;
			if (rtmp >= {1'b0, div_d_q}) begin
				rtmp       = rtmp - {1'b0, div_d_q};
				dq_next[0] = 1'b1;
			end
			rem_next = rtmp[DDW-1:0];
		end
	end

	always_comb begin
		qsig      = neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
		rate_new  = ictf_pkg::sat_q16(SW'(qsig) - SW'(gyro_offset_q[ax_idx]));
		integ_new = ictf_pkg::sat_q16(SW'(qsig) + SW'(integ_q[ax_idx]));
	end

	// shared multiplier
	always_comb begin
		case (state_q)
			ictf_pkg::S_MIX_A: begin
				mul_a = ictf_pkg::MUL_AW'(integ_q[{1'b0, axis_q}]);
				mul_b = $signed({1'b0, gyro_weight_q});
			end
			ictf_pkg::S_MIX_B: begin
				mul_a = ictf_pkg::MUL_AW'(tilt_q[axis_q]);
				mul_b = $signed({1'b0, accel_weight_q});
			end
			default: begin
				mul_a = ictf_pkg::MUL_AW'(rate_q[ax_idx]);
				mul_b = $signed({2'b00, in_q.elapsed_ms});
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// cordic load: x tilt uses (ay, az+|ax|), y tilt uses (ax, az+|ay|)
	always_comb begin
		cl_y    = axis_q ? in_q.accel_raw_x : in_q.accel_raw_y;
		cl_o    = axis_q ? in_q.accel_raw_y : in_q.accel_raw_x;
		cl_omag = cl_o[15] ? 17'(-17'(cl_o)) : 17'(cl_o);
		cl_x    = 18'(in_q.accel_raw_z) + $signed({1'b0, cl_omag});
		cl_xs   = CW'(cl_x) <<< 16;
		cl_ys   = CW'(cl_y) <<< 16;
	end

	// cordic vectoring step
	always_comb begin
		atan_idx   = ictf_pkg::ATAN_IW'(step_q);
		xsh        = cx_q >>> step_q;
		ysh        = cy_q >>> step_q;
		atan_v     = $signed({10'd0, ictf_pkg::ATAN_DEG_Q16[atan_idx]});
		cordic_end = (step_q == STEP_W'(CORDIC_STEPS)) || (cy_q == '0);
		zs         = cz_q >>> accel_range_q;
		tilt_new   = axis_q ? -zs : zs;
	end

	// mix: weighted sum / 65536, rounded half away from zero
	always_comb begin
		msum      = (PW+1)'(acc_q) + (PW+1)'(prod_q);
		mmag      = msum[PW] ? (PW+1)'(-msum) : (PW+1)'(msum);
		mr        = (mmag + (PW+1)'(32768)) >> 16;
		mval      = msum[PW] ? -$signed(mr) : $signed(mr);
		angle_new = ictf_pkg::sat_q16(SW'(mval));
	end

	assign out_load = (state_q == ictf_pkg::S_DONE) && (!out_valid_q || results.ready);
	assign g_shift  = 3'd2 + {1'b0, accel_range_q};

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_d       = state_q;
		job_d         = job_q;
		samples.ready = 1'b0;
		case (job_q)
			ictf_pkg::JOB_TEMP:   job_d = ictf_pkg::JOB_RATE_X;
			ictf_pkg::JOB_RATE_X: job_d = ictf_pkg::JOB_RATE_Y;
			ictf_pkg::JOB_RATE_Y: job_d = ictf_pkg::JOB_RATE_Z;
			ictf_pkg::JOB_RATE_Z: job_d = ictf_pkg::JOB_INT_X;
			ictf_pkg::JOB_INT_X:  job_d = ictf_pkg::JOB_INT_Y;
			ictf_pkg::JOB_INT_Y:  job_d = ictf_pkg::JOB_INT_Z;
			default:              job_d = ictf_pkg::JOB_TEMP;
		endcase
		case (state_q)
			ictf_pkg::S_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) state_d = ictf_pkg::S_DIV_LOAD;
			end
			ictf_pkg::S_DIV_LOAD: state_d = ictf_pkg::S_DIV_RUN;
			ictf_pkg::S_DIV_RUN: begin
				if (cnt_q == ictf_pkg::DIV_CW'(ictf_pkg::DIV_ITER - 1))
					state_d = ictf_pkg::S_DIV_DONE;
			end
			ictf_pkg::S_DIV_DONE: begin
				case (job_q)
					ictf_pkg::JOB_TEMP, ictf_pkg::JOB_RATE_X, ictf_pkg::JOB_RATE_Y:
						state_d = ictf_pkg::S_DIV_LOAD;
					ictf_pkg::JOB_INT_Z: state_d = ictf_pkg::S_CORDIC_LOAD;
					default:             state_d = ictf_pkg::S_MUL;
				endcase
			end
			ictf_pkg::S_MUL:         state_d = ictf_pkg::S_DIV_LOAD;
			ictf_pkg::S_CORDIC_LOAD: state_d = ictf_pkg::S_CORDIC_RUN;
			ictf_pkg::S_CORDIC_RUN: begin
				if (cordic_end)
					state_d = axis_q ? ictf_pkg::S_MIX_A : ictf_pkg::S_CORDIC_LOAD;
			end
			ictf_pkg::S_MIX_A: state_d = ictf_pkg::S_MIX_B;
			ictf_pkg::S_MIX_B: state_d = ictf_pkg::S_MIX_C;
			ictf_pkg::S_MIX_C: state_d = axis_q ? ictf_pkg::S_DONE : ictf_pkg::S_MIX_A;
			ictf_pkg::S_DONE: begin
				if (out_load) state_d = ictf_pkg::S_IDLE;
			end
			default: state_d = ictf_pkg::S_IDLE;
		endcase
	end

	// control state, registers and gyro integrals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ictf_pkg::S_IDLE;
			job_q          <= ictf_pkg::JOB_TEMP;
			gyro_range_q   <= ictf_pkg::GYRO_RANGE_RST;
			accel_range_q  <= ictf_pkg::ACCEL_RANGE_RST;
			gyro_offset_q  <= '{default: '0};
			accel_weight_q <= ictf_pkg::ACCEL_WEIGHT_RST;
			gyro_weight_q  <= ictf_pkg::GYRO_WEIGHT_RST;
			integ_q        <= '{default: '0};
			seeded_q       <= 1'b0;
			out_valid_q    <= 1'b0;
			cnt_q          <= '0;
			step_q         <= '0;
			axis_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					ictf_pkg::CFG_GYRO_RANGE_SEL:  gyro_range_q     <= cfg_wdata[1:0];
					ictf_pkg::CFG_ACCEL_RANGE_SEL: accel_range_q    <= cfg_wdata[1:0];
					ictf_pkg::CFG_GYRO_OFFSET_X:   gyro_offset_q[0] <= cfg_wdata;
					ictf_pkg::CFG_GYRO_OFFSET_Y:   gyro_offset_q[1] <= cfg_wdata;
					ictf_pkg::CFG_GYRO_OFFSET_Z:   gyro_offset_q[2] <= cfg_wdata;
					ictf_pkg::CFG_ACCEL_WEIGHT:    accel_weight_q   <= cfg_wdata[16:0];
					ictf_pkg::CFG_GYRO_WEIGHT:     gyro_weight_q    <= cfg_wdata[16:0];
					default: ;
				endcase
			end
			case (state_q)
				ictf_pkg::S_IDLE: begin
					job_q  <= ictf_pkg::JOB_TEMP;
					axis_q <= 1'b0;
				end
				ictf_pkg::S_DIV_LOAD: cnt_q <= '0;
				ictf_pkg::S_DIV_RUN:  cnt_q <= cnt_q + 1'b1;
				ictf_pkg::S_DIV_DONE: begin
					job_q <= job_d;
					if (job_q == ictf_pkg::JOB_INT_X || job_q == ictf_pkg::JOB_INT_Y ||
						job_q == ictf_pkg::JOB_INT_Z)
						integ_q[ax_idx] <= integ_new;
				end
				ictf_pkg::S_CORDIC_LOAD: step_q <= '0;
				ictf_pkg::S_CORDIC_RUN: begin
					if (cordic_end) axis_q <= !axis_q;
					else step_q <= step_q + 1'b1;
				end
				ictf_pkg::S_MIX_C: axis_q <= !axis_q;
				ictf_pkg::S_DONE: begin
					// the first sample set seeds x and y from the tilt angles
					if (out_load && !seeded_q) begin
						integ_q[0] <= tilt_q[0];
						integ_q[1] <= tilt_q[1];
						seeded_q   <= 1'b1;
					end
				end
				default: ;
			endcase
			if (out_load) out_valid_q <= 1'b1;
			else if (results.ready) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ictf_pkg::S_IDLE: begin
				if (samples.valid) in_q <= samples.payload;
			end
			ictf_pkg::S_DIV_LOAD: begin
				dq_q    <= num_mag;
				rem_q   <= '0;
				div_d_q <= div_d;
				neg_q   <= num_neg;
			end
			ictf_pkg::S_DIV_RUN: begin
				dq_q  <= dq_next;
				rem_q <= rem_next;
			end
			ictf_pkg::S_DIV_DONE: begin
				if (job_q == ictf_pkg::JOB_TEMP) temp_q <= qsig[31:0];
				else if (job_q == ictf_pkg::JOB_RATE_X || job_q == ictf_pkg::JOB_RATE_Y ||
					job_q == ictf_pkg::JOB_RATE_Z)
					rate_q[ax_idx] <= rate_new;
			end
			ictf_pkg::S_MUL: prod_q <= mul_p;
			ictf_pkg::S_CORDIC_LOAD: begin
				// left half plane: rotate by half a turn first
				if (cl_x < 0) begin
					cx_q <= -cl_xs;
					cy_q <= -cl_ys;
					cz_q <= cl_y[15] ? -ictf_pkg::HALF_TURN_Q16 : ictf_pkg::HALF_TURN_Q16;
				end else begin
					cx_q <= cl_xs;
					cy_q <= cl_ys;
					cz_q <= '0;
				end
			end
			ictf_pkg::S_CORDIC_RUN: begin
				if (cordic_end) begin
					tilt_q[axis_q] <= tilt_new;
				end else if (cy_q > 0) begin
					cx_q <= cx_q + ysh;
					cy_q <= cy_q - xsh;
					cz_q <= cz_q + atan_v;
				end else begin
					cx_q <= cx_q - ysh;
					cy_q <= cy_q + xsh;
					cz_q <= cz_q - atan_v;
				end
			end
			ictf_pkg::S_MIX_A: prod_q <= mul_p;
			ictf_pkg::S_MIX_B: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			ictf_pkg::S_MIX_C: angle_q[axis_q] <= angle_new;
			ictf_pkg::S_DONE: begin
				if (out_load) begin
					out_q.angle_x     <= angle_q[0];
					out_q.angle_y     <= angle_q[1];
					out_q.angle_z     <= integ_q[2];
					out_q.tilt_acc_x  <= tilt_q[0];
					out_q.tilt_acc_y  <= tilt_q[1];
					out_q.rate_x      <= rate_q[0];
					out_q.rate_y      <= rate_q[1];
					out_q.rate_z      <= rate_q[2];
					out_q.accel_g_x   <= 32'(in_q.accel_raw_x) <<< g_shift;
					out_q.accel_g_y   <= 32'(in_q.accel_raw_y) <<< g_shift;
					out_q.accel_g_z   <= 32'(in_q.accel_raw_z) <<< g_shift;
					out_q.temperature <= temp_q;
				end
			end
			default: ;
		endcase
	end

	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`ICTF_ASSERT_NXT(a_accept_starts, clk, arst_n, samples.valid && samples.ready, state_q == ictf_pkg::S_DIV_LOAD)
	`ICTF_ASSERT_IMP(a_rem_below_div, clk, arst_n, state_q == ictf_pkg::S_DIV_RUN, rem_q < div_d_q)
	`ICTF_ASSERT_IMP(a_step_bound, clk, arst_n, 1'b1, step_q <= STEP_W'(CORDIC_STEPS))
	`ICTF_ASSERT_NXT(a_seed_after_result, clk, arst_n, out_load, seeded_q && out_valid_q)

endmodule

// ===== verif/tb_imu_tilt_complementary_filter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_imu_tilt_complementary_filter_unit
// self-checking bench for the six-axis complementary tilt filter: a bit-exact
// predictor follows every accepted sample set, each result is compared field
// by field, over several register settings and idle/stall patterns
// ----------------------------------------------------------------------------
module tb_imu_tilt_complementary_filter_unit;

	localparam int STEPS = 16;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;
	localparam longint RATE_DIV_X10 [0:3] = '{1310, 655, 328, 164};
	localparam string FIELD_NAME [0:11] = '{"angle_x", "angle_y", "angle_z",
		"tilt_acc_x", "tilt_acc_y", "rate_x", "rate_y", "rate_z",
		"accel_g_x", "accel_g_y", "accel_g_z", "temperature"};
	// register index past the end of the list, writes to it are ignored
	localparam logic [ictf_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ictf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_wdata;

	ictf_stream_if #(.payload_t(ictf_pkg::in_item_t))  samples_if();
	ictf_stream_if #(.payload_t(ictf_pkg::out_item_t)) results_if();

	imu_tilt_complementary_filter_unit #(.CORDIC_STEPS(STEPS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if.sink),
		.results(results_if.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// mirror of the register file
	logic [1:0] gyro_sel_m;
	logic [1:0] accel_sel_m;
	longint ofs_x_m, ofs_y_m, ofs_z_m;
	longint accel_w_m, gyro_w_m;
	// mirror of the filter state
	longint integ_x, integ_y, integ_z;
	bit     seeded_m;

	ictf_pkg::out_item_t expected_results[$];
	int fail_count;
	int send_idle_pct;
	int recv_stall_pct;

	always #6 clk = ~clk;

	initial begin
		#40000000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic longint sat32(longint v);
		if (v > Q_MAX) begin
			return Q_MAX;
		end
		if (v < Q_MIN) begin
			return Q_MIN;
		end
		return v;
	endfunction

	// round to nearest, ties away from zero
	function automatic longint div_round(longint n, longint d);
		if (n >= 0) begin
			return (n + d / 2) / d;
		end
		return -((-n + d / 2) / d);
	endfunction

	// vectoring cordic, result in q16.16 degrees
	function automatic longint atan2_q16(longint y, longint x);
		longint z;
		longint xs;
		longint ys;
		z = 0;
		if (y == 0 && x == 0) begin
			return 0;
		end
		y = y * 65536;
		x = x * 65536;
		// left half plane: rotate by half a turn first
		if (x < 0) begin
			z = (y >= 0) ? 180 * 65536 : -180 * 65536;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(ictf_pkg::ATAN_DEG_Q16[i]);
			end else if (y < 0) begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(ictf_pkg::ATAN_DEG_Q16[i]);
			end else begin
				break;
			end
		end
		return z;
	endfunction

	function automatic longint rate_dps(longint raw, longint ofs);
		return sat32(div_round(raw * 655360, RATE_DIV_X10[gyro_sel_m]) - ofs);
	endfunction

	function automatic longint blend(longint integ, longint tilt);
		return sat32(div_round(gyro_w_m * integ + accel_w_m * tilt, 65536));
	endfunction

	// advance the filter state by one sample set and return its outputs
	function automatic ictf_pkg::out_item_t filter_step(ictf_pkg::in_item_t s);
		ictf_pkg::out_item_t r;
		longint ax, ay, az, ms, tx, ty, rx, ry, rz;
		ax = longint'(s.accel_raw_x);
		ay = longint'(s.accel_raw_y);
		az = longint'(s.accel_raw_z);
		ms = longint'(s.elapsed_ms);
		tx = atan2_q16(ay, az + (ax < 0 ? -ax : ax)) >>> accel_sel_m;
		ty = -(atan2_q16(ax, az + (ay < 0 ? -ay : ay)) >>> accel_sel_m);
		rx = rate_dps(longint'(s.gyro_raw_x), ofs_x_m);
		ry = rate_dps(longint'(s.gyro_raw_y), ofs_y_m);
		rz = rate_dps(longint'(s.gyro_raw_z), ofs_z_m);
		integ_x = sat32(integ_x + div_round(rx * ms, 1000));
		integ_y = sat32(integ_y + div_round(ry * ms, 1000));
		integ_z = sat32(integ_z + div_round(rz * ms, 1000));
		r.angle_x     = 32'(blend(integ_x, tx));
		r.angle_y     = 32'(blend(integ_y, ty));
		r.angle_z     = 32'(integ_z);
		r.tilt_acc_x  = 32'(tx);
		r.tilt_acc_y  = 32'(ty);
		r.rate_x      = 32'(rx);
		r.rate_y      = 32'(ry);
		r.rate_z      = 32'(rz);
		r.accel_g_x   = 32'(ax <<< (2 + accel_sel_m));
		r.accel_g_y   = 32'(ay <<< (2 + accel_sel_m));
		r.accel_g_z   = 32'(az <<< (2 + accel_sel_m));
		r.temperature = 32'(div_round((longint'(s.temp_raw) + 12412) * 65536, 340));
		// first set after reset seeds x and y from the tilt angles
		if (!seeded_m) begin
			integ_x = tx;
			integ_y = ty;
			seeded_m = 1;
		end
		return r;
	endfunction

	// result checker, compares field by field against the oldest prediction
	always @(posedge clk) begin
		ictf_pkg::out_item_t want;
		ictf_pkg::out_item_t got;
		if (results_if.valid && results_if.ready) begin
			got = results_if.payload;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result transfer %h", $time, got);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				for (int k = 0; k < 12; k++) begin
					if (want[383-32*k -: 32] !== got[383-32*k -: 32]) begin
						$display("%0t: %s expected %h actual %h", $time, FIELD_NAME[k],
							want[383-32*k -: 32], got[383-32*k -: 32]);
						fail_count++;
					end
				end
			end
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// one register write; caller closes a burst with close_writes
	task automatic write_reg(logic [ictf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			ictf_pkg::CFG_GYRO_RANGE_SEL:  gyro_sel_m  = val[1:0];
			ictf_pkg::CFG_ACCEL_RANGE_SEL: accel_sel_m = val[1:0];
			ictf_pkg::CFG_GYRO_OFFSET_X:   ofs_x_m     = longint'(signed'(val));
			ictf_pkg::CFG_GYRO_OFFSET_Y:   ofs_y_m     = longint'(signed'(val));
			ictf_pkg::CFG_GYRO_OFFSET_Z:   ofs_z_m     = longint'(signed'(val));
			ictf_pkg::CFG_ACCEL_WEIGHT:    accel_w_m   = longint'(val[16:0]);
			ictf_pkg::CFG_GYRO_WEIGHT:     gyro_w_m    = longint'(val[16:0]);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic close_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(logic [1:0] gsel, logic [1:0] asel, logic [31:0] ox,
			logic [31:0] oy, logic [31:0] oz, logic [16:0] aw, logic [16:0] gw);
		write_reg(ictf_pkg::CFG_GYRO_RANGE_SEL, {30'h2aaaaaaa, gsel});
		write_reg(ictf_pkg::CFG_ACCEL_RANGE_SEL, {30'h15555555, asel});
		write_reg(ictf_pkg::CFG_GYRO_OFFSET_X, ox);
		write_reg(ictf_pkg::CFG_GYRO_OFFSET_Y, oy);
		write_reg(ictf_pkg::CFG_GYRO_OFFSET_Z, oz);
		write_reg(ictf_pkg::CFG_ACCEL_WEIGHT, {15'h7fff, aw});
		write_reg(ictf_pkg::CFG_GYRO_WEIGHT, {15'h0, gw});
		close_writes();
	endtask

	// offer one sample set, predict it once the transfer happens
	task automatic send_sample(ictf_pkg::in_item_t s);
		if ($urandom_range(99) < send_idle_pct) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		samples_if.valid   <= 1'b1;
		samples_if.payload <= s;
		do @(posedge clk); while (!samples_if.ready);
		expected_results.push_back(filter_step(s));
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		samples_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	function automatic ictf_pkg::in_item_t sample_of(int ax, int ay, int az, int t,
			int gx, int gy, int gz, int ms);
		ictf_pkg::in_item_t s;
		s.accel_raw_x = 16'(ax);
		s.accel_raw_y = 16'(ay);
		s.accel_raw_z = 16'(az);
		s.temp_raw    = 16'(t);
		s.gyro_raw_x  = 16'(gx);
		s.gyro_raw_y  = 16'(gy);
		s.gyro_raw_z  = 16'(gz);
		s.elapsed_ms  = 16'(ms);
		return s;
	endfunction

	// mostly a sensor near rest with noise, some sets fully random
	function automatic ictf_pkg::in_item_t random_sample();
		ictf_pkg::in_item_t s;
		int g;
		if ($urandom_range(99) < 30) begin
			s = ictf_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
			if ($urandom_range(3) != 0) begin
				s.elapsed_ms = 16'($urandom_range(0, 100));
			end
		end else begin
			g = 16384 >> accel_sel_m;
			s = sample_of($urandom_range(0, 2 * g) - g, $urandom_range(0, 2 * g) - g,
				$urandom_range(0, 2 * g) - g / 2, $urandom_range(0, 8000) - 4000,
				$urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
				$urandom_range(0, 4000) - 2000, $urandom_range(1, 40));
		end
		return s;
	endfunction

	task automatic random_run(int n);
		for (int i = 0; i < n; i++) begin
			send_sample(random_sample());
		end
	endtask

	// run a batch through every idle/stall pattern
	task automatic run_phases(int n);
		int pat [4][2] = '{'{0, 0}, '{76, 0}, '{0, 76}, '{15, 15}};
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = pat[p][0];
			recv_stall_pct = pat[p][1];
			random_run(n);
		end
		drain();
	endtask

	// defaults after reset: the first set seeds x and y
	task automatic test_seeding();
		send_sample(sample_of(3000, -2000, 15000, 0, 100, -100, 50, 10));
		send_sample(sample_of(3000, -2000, 15000, 0, 100, -100, 50, 10));
		send_sample(sample_of(0, 0, 16384, -12412, 0, 0, 0, 20));
		drain();
	endtask

	// field extremes and atan2 corners
	task automatic test_corners();
		write_reg(CFG_UNUSED_IDX, 32'hffffffff);
		close_writes();
		send_sample(sample_of(0, 0, 0, 32767, 32767, -32768, 0, 0));
		send_sample(sample_of(5, 0, -1000, -32768, -32768, 32767, -1, 65535));
		send_sample(sample_of(-5, 0, -1000, 0, 1, 1, 1, 1));
		send_sample(sample_of(0, 1000, -1000, 1, -1, -1, -1, 1000));
		send_sample(sample_of(0, -1000, -1000, -1, 0, 0, 0, 65535));
		send_sample(sample_of(-32768, -32768, -32768, 0, 0, 0, 0, 0));
		send_sample(sample_of(32767, 32767, 32767, 0, 0, 0, 0, 65535));
		send_sample(sample_of(-32768, 32767, 0, 0, 32767, 32767, 32767, 65535));
		send_sample(sample_of(0, 0, 1, 0, -32768, -32768, -32768, 65535));
		send_sample(sample_of(16384, 16384, 0, 0, 0, 0, 0, 3));
		send_sample(sample_of(1, -1, 0, 0, 0, 0, 0, 3));
		drain();
		set_regs(2'd3, 2'd3, 32'h7fffffff, 32'h80000000, 32'h00000000,
			17'h1ffff, 17'h1ffff);
		send_sample(sample_of(-32768, 32767, -32768, 0, -32768, 32767, 0, 65535));
		send_sample(sample_of(100, -100, 2000, 0, 32767, -32768, 5, 65535));
		drain();
	endtask

	// sweep the register settings, extremes included
	task automatic test_register_sweep();
		set_regs(2'd0, 2'd0, 32'h0, 32'h0, 32'h0, 17'd1311, 17'd64225);
		run_phases(56);
		set_regs(2'd3, 2'd1, 32'h00010000, 32'hffff0000, 32'h00008000,
			17'd0, 17'd65536);
		run_phases(56);
		set_regs(2'd2, 2'd2, 32'h80000000, 32'h7fffffff, 32'h80000000,
			17'd65536, 17'd0);
		run_phases(56);
		set_regs(2'd1, 2'd3, $urandom, $urandom, $urandom, 17'd100000, 17'd131071);
		run_phases(56);
		set_regs(2'd0, 2'd3, 32'h0, 32'h0, 32'h7fffffff, 17'd0, 17'd0);
		run_phases(56);
		set_regs(2'd1, 2'd0, $urandom, $urandom, $urandom, 17'($urandom),
			17'($urandom));
		run_phases(56);
		set_regs(2'd2, 2'd1, 32'h0, 32'h0, 32'h0, 17'd6554, 17'd58982);
		run_phases(56);
	endtask

	// sender holds off mid-stream until every result is back
	task automatic test_hold_off();
		send_idle_pct  = 40;
		recv_stall_pct = 40;
		random_run(60);
		drain();
		random_run(60);
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		samples_if.valid = 1'b0;
		samples_if.payload = '0;
		results_if.ready = 1'b0;
		fail_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		gyro_sel_m = ictf_pkg::GYRO_RANGE_RST;
		accel_sel_m = ictf_pkg::ACCEL_RANGE_RST;
		ofs_x_m = 0;
		ofs_y_m = 0;
		ofs_z_m = 0;
		accel_w_m = longint'(ictf_pkg::ACCEL_WEIGHT_RST);
		gyro_w_m = longint'(ictf_pkg::GYRO_WEIGHT_RST);
		integ_x = 0;
		integ_y = 0;
		integ_z = 0;
		seeded_m = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_seeding();
		test_corners();
		test_register_sweep();
		test_hold_off();
		repeat (300) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ictf_pkg.sv
rtl/core/ictf_stream_if.sv
rtl/core/imu_tilt_complementary_filter_unit.sv
verif/tb_imu_tilt_complementary_filter_unit.sv
